// ===== hw/rtl/three_level_priority_queue_assert.svh =====
// Assertion macros used by the checker of the priority queue.
`ifndef THREE_LEVEL_PRIORITY_QUEUE_ASSERT_SVH
`define THREE_LEVEL_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define TLPQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked through reset as well.
`define TLPQ_ASSERT_NXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tlpq_pkg.sv =====
// Types and constants shared by the priority queue modules.
`default_nettype none

package tlpq_pkg;

  localparam int NUM_CLASSES = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  localparam logic [1:0] CLS_HIGH   = 2'd0;
  localparam logic [1:0] CLS_MEDIUM = 2'd1;
  localparam logic [1:0] CLS_LOW    = 2'd2;
  localparam logic [1:0] CLS_NONE   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_CLASS = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_BAD  = 2'd2
  } op_t;

  typedef struct packed {
    op_t                kind;
    logic [1:0]         cls;
    logic signed [31:0] value;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tlpq_front.sv =====
// Front end: accepts commands, classifies them and hands them to the queue.
`default_nettype none

module tlpq_front import tlpq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               func,
  input  logic signed [31:0] value,
  input  logic [1:0]         priority_req,
  output logic               busy,
  input  logic               q_full,
  output logic               q_push,
  output cmd_t               q_cmd
);

  logic held;
  logic take;
  cmd_t cmd_next;

  assign busy   = held && q_full;
  assign take   = start && !busy;
  assign q_push = held && !q_full;

  always_comb begin
    cmd_next.value = value;
    cmd_next.cls   = priority_req;
    if (func == FUNC_POP) begin
      cmd_next.kind = OP_POP;
    end else if (priority_req == CLS_NONE) begin
      cmd_next.kind = OP_BAD;
    end else begin
      cmd_next.kind = OP_PUSH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (q_push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      q_cmd <= cmd_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tlpq_fifo.sv =====
// Short command queue between the front end and the back end.
`default_nettype none

module tlpq_fifo import tlpq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] used;
  logic             do_push;
  logic             do_pop;

  assign full    = (used == CNT_W'(QUEUE_DEPTH));
  assign empty   = (used == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        used <= used + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        used <= used - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tlpq_store.sv =====
// Storage for one priority class: one write port, one registered read port.
`default_nettype none

module tlpq_store #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tlpq_back.sv =====
// Back end: carries out pushes and pops and reports the queue state.
`default_nettype none

module tlpq_back import tlpq_pkg::*; #(
  parameter int CLASS_DEPTH = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  cmd_t               q_head,
  output logic               q_pop,
  output logic               done,
  output logic [1:0]         status,
  output logic               head_valid,
  output logic signed [31:0] head_value,
  output logic [1:0]         head_class,
  output logic [4:0]         count_high,
  output logic [4:0]         count_medium,
  output logic [4:0]         count_low,
  output logic [5:0]         count_total
);

  localparam int SLOT_W = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
  localparam int CNT_W  = $clog2(CLASS_DEPTH + 1);
  localparam int TOT_W  = CNT_W + 2;
  localparam int EXT_W  = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

  typedef enum logic [2:0] {
    S_EXEC   = 3'b001,
    S_LOOK   = 3'b010,
    S_REPORT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0]      fill_arr  [NUM_CLASSES];
  logic                  full_arr  [NUM_CLASSES];
  logic [DATA_WIDTH-1:0] rdata_arr [NUM_CLASSES];

  logic                  full_sel;
  logic [1:0]            top_c;
  logic [1:0]            top_q;
  logic [1:0]            status_next;
  logic [1:0]            status_q;
  logic                  exec_push;
  logic                  exec_pop;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_WIDTH-1:0] rd_sel;
  logic [TOT_W-1:0]      total;

  assign wr_data = DATA_WIDTH'(EXT_W'(q_head.value));

  always_comb begin
    priority if (fill_arr[0] != '0) begin
      top_c = CLS_HIGH;
    end else if (fill_arr[1] != '0) begin
      top_c = CLS_MEDIUM;
    end else if (fill_arr[2] != '0) begin
      top_c = CLS_LOW;
    end else begin
      top_c = CLS_NONE;
    end
  end

  always_comb begin
    unique case (q_head.cls)
      CLS_HIGH:   full_sel = full_arr[0];
      CLS_MEDIUM: full_sel = full_arr[1];
      CLS_LOW:    full_sel = full_arr[2];
      default:    full_sel = 1'b0;
    endcase
  end

  always_comb begin
    unique case (q_head.kind)
      OP_PUSH: status_next = full_sel ? ST_FULL : ST_OK;
      OP_POP:  status_next = (top_c == CLS_NONE) ? ST_EMPTY : ST_OK;
      default: status_next = ST_BAD_CLASS;
    endcase
  end

  assign q_pop     = (state == S_EXEC) && !q_empty;
  assign exec_push = q_pop && (q_head.kind == OP_PUSH) && !full_sel;
  assign exec_pop  = q_pop && (q_head.kind == OP_POP) && (top_c != CLS_NONE);

  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_class
    logic [SLOT_W-1:0] rd_slot;
    logic [SLOT_W-1:0] wr_slot;
    logic [CNT_W-1:0]  fill;
    logic              push_hit;
    logic              pop_hit;

    assign push_hit    = exec_push && (q_head.cls == 2'(c));
    assign pop_hit     = exec_pop && (top_c == 2'(c));
    assign fill_arr[c] = fill;
    assign full_arr[c] = (fill == CNT_W'(CLASS_DEPTH));

    always_ff @(posedge clk) begin
      if (rst) begin
        rd_slot <= '0;
        wr_slot <= '0;
        fill    <= '0;
      end else begin
        if (push_hit) begin
          wr_slot <= (wr_slot == SLOT_W'(CLASS_DEPTH - 1)) ? '0 : wr_slot + SLOT_W'(1);
          fill    <= fill + CNT_W'(1);
        end else if (pop_hit) begin
          rd_slot <= (rd_slot == SLOT_W'(CLASS_DEPTH - 1)) ? '0 : rd_slot + SLOT_W'(1);
          fill    <= fill - CNT_W'(1);
        end
      end
    end

    tlpq_store #(
      .DEPTH  (CLASS_DEPTH),
      .WIDTH  (DATA_WIDTH),
      .ADDR_W (SLOT_W)
    ) u_store (
      .clk   (clk),
      .we    (push_hit),
      .waddr (wr_slot),
      .wdata (wr_data),
      .re    (state == S_LOOK),
      .raddr (rd_slot),
      .rdata (rdata_arr[c])
    );
  end

  always_comb begin
    unique case (state)
      S_EXEC:   state_next = q_pop ? S_LOOK : S_EXEC;
      S_LOOK:   state_next = S_REPORT;
      S_REPORT: state_next = S_EXEC;
      default:  state_next = S_EXEC;
    endcase
  end

  always_comb begin
    unique case (top_q)
      CLS_HIGH:   rd_sel = rdata_arr[0];
      CLS_MEDIUM: rd_sel = rdata_arr[1];
      CLS_LOW:    rd_sel = rdata_arr[2];
      default:    rd_sel = '0;
    endcase
  end

  assign total = TOT_W'(fill_arr[0]) + TOT_W'(fill_arr[1]) + TOT_W'(fill_arr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_EXEC;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_REPORT);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      status_q <= status_next;
    end
    if (state == S_LOOK) begin
      top_q <= top_c;
    end
    if (state == S_REPORT) begin
      status       <= status_q;
      head_valid   <= (top_q != CLS_NONE);
      head_value   <= 32'(EXT_W'($signed(rd_sel)));
      head_class   <= (top_q != CLS_NONE) ? top_q : CLS_HIGH;
      count_high   <= 5'(fill_arr[0]);
      count_medium <= 5'(fill_arr[1]);
      count_low    <= 5'(fill_arr[2]);
      count_total  <= 6'(total);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/three_level_priority_queue.sv =====
// Top level of the three-class strict priority queue.
//
// A command is taken at a rising edge where start is high and busy is low.
// func selects push or pop; on a push, priority_req picks the class (high,
// medium or low) and value is the word to append. Pops take the oldest word
// of the highest class that holds anything; value and priority_req are then
// ignored.
// Every accepted command gives exactly one result beat: done is high for a
// single cycle with status, the new head word and class, and the counts.
// The receiver cannot stall, so the result must be taken in that cycle.
// An accepted command passes the front register, the command queue and the
// back end's states before done rises. The back end takes each command
// through three states (execute, read the class stores, report), bound by
// the single registered read port of each class store, and takes no new
// command until it is back in execute. A two-entry command queue and a
// front register absorb short bursts; busy rises once both fill.
// Reset (synchronous, active high) empties all three classes and the command
// queue at once; the stores themselves are not cleared and need no pass.
`default_nettype none

module three_level_priority_queue import tlpq_pkg::*; #(
  parameter int CLASS_DEPTH = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               func,
  input  logic signed [31:0] value,
  input  logic [1:0]         priority_req,
  output logic               done,
  output logic [1:0]         status,
  output logic               head_valid,
  output logic signed [31:0] head_value,
  output logic [1:0]         head_class,
  output logic [4:0]         count_high,
  output logic [4:0]         count_medium,
  output logic [4:0]         count_low,
  output logic [5:0]         count_total
);

  // Front to queue.
  logic q_push;
  logic q_full;
  cmd_t q_cmd;

  // Queue to back end.
  logic q_pop;
  logic q_empty;
  cmd_t q_head;

  // The front end registers each command and classifies it as a push, a
  // pop or a push with an invalid class, so the back end never decodes
  // func itself.
  tlpq_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .func         (func),
    .value        (value),
    .priority_req (priority_req),
    .busy         (busy),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_cmd)
  );

  // The queue lets the front keep taking commands while the back end is
  // still working through an earlier one.
  tlpq_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // The back end owns the class stores, their ring positions and counts,
  // and produces the result beat.
  tlpq_back #(
    .CLASS_DEPTH (CLASS_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .done         (done),
    .status       (status),
    .head_valid   (head_valid),
    .head_value   (head_value),
    .head_class   (head_class),
    .count_high   (count_high),
    .count_medium (count_medium),
    .count_low    (count_low),
    .count_total  (count_total)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/tlpq_checker.sv =====
// Port-level checks of the priority queue and their binding to the top level.
`default_nettype none

`include "three_level_priority_queue_assert.svh"

module tlpq_checker import tlpq_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               done,
  input wire logic [1:0]         status,
  input wire logic               head_valid,
  input wire logic signed [31:0] head_value,
  input wire logic [1:0]         head_class,
  input wire logic [5:0]         count_total
);

  // The back end passes each command through its execute, look and report states, so beats never abut.
  `TLPQ_ASSERT_NXT(a_done_single, clk, done, !done, "result beats back to back")

  // Reset drops any result under way.
  `TLPQ_ASSERT_NXT(a_reset_quiet, clk, rst, !done, "result beat right after reset")

  // An empty queue reports a zero head and a zero total.
  `TLPQ_ASSERT_IMP(a_empty_head, clk, rst, done && !head_valid,
    (count_total == 6'd0) && (head_value == 32'sd0) && (head_class == CLS_HIGH),
    "empty queue with a non-zero head or count")

  // A pop that found nothing leaves nothing behind, and a valid head names a class.
  `TLPQ_ASSERT_IMP(a_pop_empty, clk, rst, done && (status == ST_EMPTY || head_valid),
    (status != ST_EMPTY || !head_valid) && (head_class != CLS_NONE),
    "inconsistent head after an access")

endmodule

bind three_level_priority_queue tlpq_checker u_checker (.*);

`default_nettype wire
